// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the brace-list parser RTL.
// Expects clk_i and rst_ni in the scope of use; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, prop)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/blip_pkg.sv -----
// Types and constants of the brace-list integer parser.
// No dependencies; imported by every blip module.
package blip_pkg;

  localparam int MAX_ITEMS  = 16;
  localparam int CHAR_W     = 8;
  localparam int VALUE_W    = 16;
  localparam int INDEX_W    = 4;
  localparam int ERR_W      = 3;
  localparam int ITEM_CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int PROD_W     = VALUE_W + 4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_OPEN,
    PH_NUM,
    PH_COMMA
  } blip_phase_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE,
    ERR_NO_OPEN,
    ERR_AFTER_OPEN,
    ERR_AFTER_COMMA,
    ERR_NON_DIGIT,
    ERR_TOO_MANY
  } blip_err_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic               last;
    blip_err_e          err;
  } blip_result_t;

endpackage

// ----- hdl/brace_list_integer_parser.sv -----
// Brace-list integer parser: one character per transfer, lists such as {4,16,3}.
// The character is held in the input register, decoded, then loaded into the result register.
// Throughput: one character per cycle; a stalled result register holds a character that yields a result.
// Rate is set by the input register, combinational decode and result register path.
// Reset: asynchronous, active low; parser idle, accumulator and item count cleared.
module brace_list_integer_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [blip_pkg::CHAR_W-1:0]   char_code_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [blip_pkg::VALUE_W-1:0]  item_value_o,
  output logic [blip_pkg::INDEX_W-1:0]  item_index_o,
  output logic                          last_item_o,
  output logic [blip_pkg::ERR_W-1:0]    error_code_o
);
  import blip_pkg::*;

  logic              held_valid;
  logic [CHAR_W-1:0] held_char;
  logic              has_result;
  logic              out_free;
  logic              advance;
  blip_result_t      core_result;
  blip_result_t      out_result;

  assign advance = held_valid && (!has_result || out_free);

  blip_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .char_i       (char_code_i),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_char_o  (held_char)
  );

  blip_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_i       (held_char),
    .fire_i       (advance),
    .has_result_o (has_result),
    .result_o     (core_result)
  );

  blip_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (advance && has_result),
    .result_i (core_result),
    .free_o   (out_free),
    .valid_o  (valid_o),
    .stall_i  (stall_i),
    .result_o (out_result)
  );

  assign item_value_o = out_result.value;
  assign item_index_o = out_result.index;
  assign last_item_o  = out_result.last;
  assign error_code_o = out_result.err;

endmodule

// ----- hdl/blip_in_reg.sv -----
// Input character register of the brace-list parser.
// Depends on blip_pkg.
module blip_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [blip_pkg::CHAR_W-1:0] char_i,
  input  logic                       advance_i,
  output logic                       held_valid_o,
  output logic [blip_pkg::CHAR_W-1:0] held_char_o
);
  import blip_pkg::*;

  logic              valid_q;
  logic [CHAR_W-1:0] char_q;

  assign stall_o = valid_q && !advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      char_q <= char_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_char_o  = char_q;

endmodule

// ----- hdl/blip_core.sv -----
// Parse state and per-character decode of the brace-list parser.
// Depends on blip_pkg and assert_macros.svh.
`include "assert_macros.svh"

module blip_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [blip_pkg::CHAR_W-1:0] char_i,
  input  logic                        fire_i,
  output logic                        has_result_o,
  output blip_pkg::blip_result_t      result_o
);
  import blip_pkg::*;

  blip_phase_e           phase_q, phase_d;
  logic [VALUE_W-1:0]    acc_q, acc_d;
  logic [ITEM_CNT_W-1:0] cnt_q, cnt_d;

  logic      is_digit;
  logic      do_fail, do_emit, emit_last, do_digit;
  blip_err_e fail_err;
  logic      too_many;
  logic [3:0]        digit;
  logic [PROD_W-1:0] prod;
  logic [VALUE_W-1:0] acc_next;

  assign is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign digit    = 4'(char_i - CH_ZERO);
  assign prod     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + PROD_W'(digit);
  assign acc_next = (prod > PROD_W'(VALUE_MAX)) ? VALUE_MAX : prod[VALUE_W-1:0];
  assign too_many = cnt_q >= ITEM_CNT_W'(MAX_ITEMS);

  // character classification per phase
  always_comb begin
    do_fail   = 1'b0;
    fail_err  = ERR_NONE;
    do_emit   = 1'b0;
    emit_last = 1'b0;
    do_digit  = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (char_i != CH_OPEN) begin
          do_fail  = 1'b1;
          fail_err = ERR_NO_OPEN;
        end
      end
      PH_OPEN: begin
        if (char_i == CH_COMMA || char_i == CH_OPEN) begin
          do_fail  = 1'b1;
          fail_err = ERR_AFTER_OPEN;
        end else if (char_i == CH_CLOSE) begin
          do_emit   = 1'b1;
          emit_last = 1'b1;
        end else if (is_digit) begin
          do_digit = 1'b1;
        end else begin
          do_fail  = 1'b1;
          fail_err = ERR_NON_DIGIT;
        end
      end
      PH_NUM: begin
        if (char_i == CH_COMMA || char_i == CH_CLOSE) begin
          do_emit   = 1'b1;
          emit_last = (char_i == CH_CLOSE);
        end else if (is_digit) begin
          do_digit = 1'b1;
        end else begin
          do_fail  = 1'b1;
          fail_err = ERR_NON_DIGIT;
        end
      end
      default: begin
        if (char_i == CH_COMMA || char_i == CH_CLOSE) begin
          do_fail  = 1'b1;
          fail_err = ERR_AFTER_COMMA;
        end else if (is_digit) begin
          do_digit = 1'b1;
        end else begin
          do_fail  = 1'b1;
          fail_err = ERR_NON_DIGIT;
        end
      end
    endcase
    if (do_emit && too_many) begin
      do_emit  = 1'b0;
      do_fail  = 1'b1;
      fail_err = ERR_TOO_MANY;
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    if (do_fail) begin
      phase_d = PH_IDLE;
      acc_d   = '0;
      cnt_d   = '0;
    end else if (do_emit) begin
      acc_d = '0;
      if (emit_last) begin
        phase_d = PH_IDLE;
        cnt_d   = '0;
      end else begin
        phase_d = PH_COMMA;
        cnt_d   = ITEM_CNT_W'(cnt_q + 1'b1);
      end
    end else if (do_digit) begin
      phase_d = PH_NUM;
      acc_d   = acc_next;
    end else begin
      // opening brace while idle
      phase_d = PH_OPEN;
      acc_d   = '0;
      cnt_d   = '0;
    end
  end

  // result
  always_comb begin
    has_result_o   = do_fail || do_emit;
    result_o.index = (phase_q == PH_IDLE) ? '0 : INDEX_W'(cnt_q);
    if (do_fail) begin
      result_o.value = '0;
      result_o.last  = 1'b1;
      result_o.err   = fail_err;
    end else begin
      result_o.value = acc_q;
      result_o.last  = emit_last;
      result_o.err   = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  `ASSERT_IMPLIES(a_err_ends_list, has_result_o && result_o.err != ERR_NONE,
                  result_o.last && result_o.value == '0)
  `ASSERT_NEXT(a_last_resets, fire_i && has_result_o && result_o.last,
               phase_q == PH_IDLE && cnt_q == '0 && acc_q == '0)
  `ASSERT_NEXT(a_silent_enters_list, fire_i && !has_result_o, phase_q != PH_IDLE)
  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= ITEM_CNT_W'(MAX_ITEMS))

endmodule

// ----- hdl/blip_out_reg.sv -----
// Result register of the brace-list parser.
// Depends on blip_pkg.
module blip_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  blip_pkg::blip_result_t result_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  logic                   stall_i,
  output blip_pkg::blip_result_t result_o
);
  import blip_pkg::*;

  logic         valid_q;
  blip_result_t result_q;

  assign free_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && push_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- verif/brace_list_integer_parser_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for brace_list_integer_parser: feeds character streams,
// predicts each result in SystemVerilog and compares every result transfer.
// Depends on blip_pkg and the brace_list_integer_parser RTL.
module brace_list_integer_parser_tb;
  import blip_pkg::*;

  localparam int CHAR_COUNT = 1550;
  localparam int TAIL_CHARS = 150;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                valid_i = 1'b0;
  logic                stall_o;
  logic [CHAR_W-1:0]   char_code_i = '0;
  logic                valid_o;
  logic                stall_i = 1'b0;
  logic [VALUE_W-1:0]  item_value_o;
  logic [INDEX_W-1:0]  item_index_o;
  logic                last_item_o;
  logic [ERR_W-1:0]    error_code_o;

  brace_list_integer_parser dut (
    .clk_i,
    .rst_ni,
    .valid_i,
    .stall_o,
    .char_code_i,
    .valid_o,
    .stall_i,
    .item_value_o,
    .item_index_o,
    .last_item_o,
    .error_code_o
  );

  logic [CHAR_W-1:0] text_chars[$];
  blip_result_t      expected_items[$];

  blip_phase_e           list_phase = PH_IDLE;
  logic [VALUE_W-1:0]    number_acc = '0;
  logic [ITEM_CNT_W-1:0] item_count = '0;

  int  offered_count = 0;
  int  taken_count = 0;
  int  send_gap = 0;
  int  hold_cnt = 0;
  bit  long_hold_done = 1'b0;
  int  errors = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Predictor of the list parser.
  task automatic abort_list(input blip_err_e err);
    blip_result_t r;
    r.value = '0;
    r.index = item_count[INDEX_W-1:0];
    r.last  = 1'b1;
    r.err   = err;
    expected_items.push_back(r);
    list_phase = PH_IDLE;
    number_acc = '0;
    item_count = '0;
  endtask

  task automatic close_item(input logic last);
    blip_result_t r;
    if (item_count >= ITEM_CNT_W'(MAX_ITEMS)) begin
      abort_list(ERR_TOO_MANY);
    end else begin
      r.value = number_acc;
      r.index = item_count[INDEX_W-1:0];
      r.last  = last;
      r.err   = ERR_NONE;
      expected_items.push_back(r);
      number_acc = '0;
      if (last) begin
        list_phase = PH_IDLE;
        item_count = '0;
      end else begin
        list_phase = PH_COMMA;
        item_count = item_count + 1'b1;
      end
    end
  endtask

  task automatic take_digit(input logic [CHAR_W-1:0] c);
    logic [PROD_W-1:0] sum;
    sum = PROD_W'(number_acc) * PROD_W'(10) + PROD_W'(c - CH_ZERO);
    number_acc = (sum > PROD_W'(VALUE_MAX)) ? VALUE_MAX : sum[VALUE_W-1:0];
    list_phase = PH_NUM;
  endtask

  task automatic parse_char(input logic [CHAR_W-1:0] c);
    logic is_digit;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (list_phase)
      PH_IDLE: begin
        if (c == CH_OPEN) begin
          list_phase = PH_OPEN;
          number_acc = '0;
          item_count = '0;
        end else begin
          abort_list(ERR_NO_OPEN);
        end
      end
      PH_OPEN: begin
        if (c == CH_COMMA || c == CH_OPEN) abort_list(ERR_AFTER_OPEN);
        else if (c == CH_CLOSE) close_item(1'b1);
        else if (is_digit) take_digit(c);
        else abort_list(ERR_NON_DIGIT);
      end
      PH_NUM: begin
        if (c == CH_COMMA) close_item(1'b0);
        else if (c == CH_CLOSE) close_item(1'b1);
        else if (is_digit) take_digit(c);
        else abort_list(ERR_NON_DIGIT);
      end
      default: begin
        if (c == CH_COMMA || c == CH_CLOSE) abort_list(ERR_AFTER_COMMA);
        else if (is_digit) take_digit(c);
        else abort_list(ERR_NON_DIGIT);
      end
    endcase
  endtask

  // Stimulus text.
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_chars.push_back(s[i]);
  endtask

  task automatic add_random_list();
    int  kind;
    int  n_items;
    int  n_digits;
    bit  broken;
    kind = $urandom_range(0, 99);
    if (kind < 5) n_items = 0;
    else if (kind < 15) n_items = $urandom_range(15, 18);
    else n_items = $urandom_range(1, 5);
    broken = ($urandom_range(0, 9) == 0);
    text_chars.push_back(CH_OPEN);
    for (int i = 0; i < n_items; i++) begin
      if (i > 0) text_chars.push_back(CH_COMMA);
      n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
      for (int d = 0; d < n_digits; d++) text_chars.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
      if (broken && $urandom_range(0, n_items) == 0)
        text_chars.push_back(CHAR_W'($urandom_range(0, 255)));
    end
    text_chars.push_back(CH_CLOSE);
  endtask

  initial begin
    text_chars.push_back(8'h00);
    text_chars.push_back(8'hFF);
    add_text("{}");
    add_text("{,");
    add_text("{{");
    add_text("{1,,");
    add_text("{1,}");
    add_text("{99999}");
    add_text("{7x");
    while (text_chars.size() < CHAR_COUNT) begin
      if ($urandom_range(0, 9) < 8) begin
        add_random_list();
      end else begin
        repeat ($urandom_range(1, 4)) text_chars.push_back(CHAR_W'($urandom_range(0, 255)));
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Character driver.
  always @(negedge clk_i) begin
    if (rst_ni && (!valid_i || taken_count == offered_count)) begin
      if (send_gap != 0) begin
        valid_i <= 1'b0;
        send_gap = send_gap - 1;
      end else if (text_chars.size() == 0) begin
        valid_i <= 1'b0;
      end else if (text_chars.size() > TAIL_CHARS && (offered_count / 200) % 2 == 1 &&
                   $urandom_range(0, 5) == 0) begin
        valid_i <= 1'b0;
        send_gap = $urandom_range(1, 9) - 1;
      end else begin
        char_code_i <= text_chars.pop_front();
        valid_i <= 1'b1;
        offered_count = offered_count + 1;
      end
    end
  end

  // Result receiver; one long hold-off to back the block up.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && taken_count >= 400) begin
        long_hold_done = 1'b1;
        hold_cnt = 80;
      end
      if (hold_cnt != 0) begin
        stall_i <= 1'b1;
        hold_cnt = hold_cnt - 1;
      end else if (text_chars.size() > TAIL_CHARS && (taken_count / 150) % 2 == 1 &&
                   $urandom_range(0, 5) == 0) begin
        stall_i <= 1'b1;
        hold_cnt = $urandom_range(1, 9) - 1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_i && !stall_o) begin
      parse_char(char_code_i);
      taken_count = taken_count + 1;
    end
  end

  always @(posedge clk_i) begin
    blip_result_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_items.size() == 0) begin
        $display("%0t: unexpected result value=%0d index=%0d last=%0b err=%0d", $realtime,
                 item_value_o, item_index_o, last_item_o, error_code_o);
        errors = errors + 1;
      end else begin
        want = expected_items.pop_front();
        if (item_value_o !== want.value || item_index_o !== want.index ||
            last_item_o !== want.last || error_code_o !== want.err) begin
          $display("%0t: expected value=%0d index=%0d last=%0b err=%0d, got value=%0d index=%0d last=%0b err=%0d",
                   $realtime, want.value, want.index, want.last, want.err,
                   item_value_o, item_index_o, last_item_o, error_code_o);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    do @(posedge clk_i);
    while (text_chars.size() != 0 || valid_i || expected_items.size() != 0);
    repeat (20) @(posedge clk_i);
    if (expected_items.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, expected_items.size());
      errors = errors + 1;
    end
    if (errors == 0) begin
      $display("brace_list_integer_parser: match");
    end else begin
      $display("brace_list_integer_parser: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("brace_list_integer_parser: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/blip_pkg.sv
hdl/blip_in_reg.sv
hdl/blip_core.sv
hdl/blip_out_reg.sv
hdl/brace_list_integer_parser.sv
verif/brace_list_integer_parser_tb.sv
